// ----- rtl/smc_pkg.sv -----
// ----------------------------------------------------------------------------
// smc_pkg: shared definitions for the stack machine core
// Sizes, opcodes, fault codes, sequencer states, ALU request and the
// payload structs of the request and result channels.
// ----------------------------------------------------------------------------
package smc_pkg;

  // Storage sizes and word width.
  localparam int MEM_WORDS        = 4096;
  localparam int DATA_STACK_WORDS = 2048;
  localparam int CALL_STACK_WORDS = 2048;
  localparam int WORD_BITS        = 32;

  // Derived widths.
  localparam int MEM_AW = $clog2(MEM_WORDS);
  localparam int DS_AW  = $clog2(DATA_STACK_WORDS);
  localparam int CS_AW  = $clog2(CALL_STACK_WORDS);
  localparam int DCW    = $clog2(DATA_STACK_WORDS + 1);
  localparam int CCW    = $clog2(CALL_STACK_WORDS + 1);
  localparam int RA_W   = MEM_AW + 1;

  // Fixed widths of the channel fields.
  localparam int OPER_W  = 2;
  localparam int ADDR_W  = 12;
  localparam int DATA_W  = 32;
  localparam int DEPTH_W = 12;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [OPER_W-1:0] {
    OPER_LOAD = 2'd0,
    OPER_EXEC = 2'd1,
    OPER_READ = 2'd2,
    OPER_NONE = 2'd3
  } oper_t;

  typedef enum logic [4:0] {
    OP_PUSH = 5'd0, OP_POP = 5'd1, OP_PRINT = 5'd2, OP_ADD = 5'd3,
    OP_SUB = 5'd4, OP_MULT = 5'd5, OP_DIV = 5'd6, OP_JMP = 5'd7,
    OP_CMP = 5'd8, OP_JE = 5'd9, OP_JNE = 5'd10, OP_JL = 5'd11,
    OP_JG = 5'd12, OP_JLE = 5'd13, OP_JGE = 5'd14, OP_FROMMEM = 5'd15,
    OP_TOMEM = 5'd16, OP_RFROMMEM = 5'd17, OP_RTOMEM = 5'd18, OP_CALL = 5'd19,
    OP_RET = 5'd20, OP_DUP = 5'd21, OP_RANDINT = 5'd22, OP_SWAP = 5'd23,
    OP_INC = 5'd24, OP_DEC = 5'd25, OP_AFROMMEM = 5'd26, OP_ATOMEM = 5'd27,
    OP_NOP = 5'd28, OP_QUIT = 5'd29, OP_BREAK = 5'd30
  } opcode_t;

  typedef enum logic [3:0] {
    FLT_NONE = 4'd0, FLT_CODE_END = 4'd1, FLT_OVERFLOW = 4'd2,
    FLT_UNDERFLOW = 4'd3, FLT_BAD_ADDR = 4'd4, FLT_CALL_OVF = 4'd5,
    FLT_CALL_EMPTY = 4'd6, FLT_BAD_DUP = 4'd7, FLT_BAD_OP = 4'd8,
    FLT_DIV_ZERO = 4'd9
  } fault_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MEMRD, ST_FETCH, ST_OPND, ST_EXEC, ST_ALU, ST_MPUSH,
    ST_SWAP2, ST_DUPRD, ST_DUPWR, ST_COMMIT, ST_TOP, ST_RESP, ST_WAIT
  } state_t;

  typedef enum logic [2:0] {
    ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_INC, ALU_DEC
  } alu_func_t;

  typedef struct packed {
    logic      start;
    alu_func_t func;
  } alu_req_t;

  typedef struct packed {
    logic [OPER_W-1:0]  operation;
    logic [ADDR_W-1:0]  address;
    logic [DATA_W-1:0]  write_data;
    logic [DATA_W-1:0]  random_value;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic [ADDR_W-1:0]  program_counter;
    logic [DEPTH_W-1:0] stack_depth;
    logic [DATA_W-1:0]  top_value;
    logic [DEPTH_W-1:0] call_depth;
    logic               flag_equal;
    logic               flag_greater;
    logic               halted;
    logic [3:0]         fault_code;
  } out_t;

endpackage

// ----- rtl/stack_machine_core.sv -----
// ----------------------------------------------------------------------------
// stack_machine_core: 32-bit stack processor with shared code and data memory
// Sequencer around a shared ALU, a main memory, a data stack and a call stack.
// ----------------------------------------------------------------------------
// Usage: each request on the in_ channel loads a memory word, reads one back
// or executes the instruction at the program counter. Every request gives
// exactly one result on the out_ channel: the word read (zero otherwise) and
// a snapshot of pc, stack depths, top of stack, flags and fault state.
// A divide runs on the one-bit-per-cycle divider; dup reads each copied
// word and then writes its copy, since every word passes through the
// single data stack read port.
// The core takes one request at a time: in_ready is high only when the
// sequencer is idle and the previous result has been taken. A stalled
// receiver leaves the core holding the result until it is taken.
// Reset clears pc, depths, flags and the fault state; memory and stacks
// hold unknown contents until written and need no clearing pass.
// A fault or quit halts the core; later execute requests are ignored while
// loads and reads are still served.
// ----------------------------------------------------------------------------
module stack_machine_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  smc_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output smc_pkg::out_t  out_data
);

  localparam int W      = smc_pkg::WORD_BITS;
  localparam int MEM_AW = smc_pkg::MEM_AW;
  localparam int DS_AW  = smc_pkg::DS_AW;
  localparam int CS_AW  = smc_pkg::CS_AW;
  localparam int DCW    = smc_pkg::DCW;
  localparam int CCW    = smc_pkg::CCW;
  localparam int RA_W   = smc_pkg::RA_W;
  localparam logic [W-1:0]   MEM_W   = W'(smc_pkg::MEM_WORDS);
  localparam logic [W:0]     DSW_X   = (W + 1)'(smc_pkg::DATA_STACK_WORDS);
  localparam logic [DCW-1:0] DS_FULL = DCW'(smc_pkg::DATA_STACK_WORDS);
  localparam logic [CCW-1:0] CS_FULL = CCW'(smc_pkg::CALL_STACK_WORDS);
  localparam logic [RA_W-1:0] MEM_RA = RA_W'(smc_pkg::MEM_WORDS);

  // Architectural and sequencer registers.
  smc_pkg::state_t  state_r, state_nxt;
  logic [MEM_AW-1:0] pc_r, pc_nxt, pend_pc_r, pend_pc_nxt;
  logic [DCW-1:0]   d_r, d_nxt, pend_d_r, pend_d_nxt;
  logic [CCW-1:0]   r_r, r_nxt, pend_r_r, pend_r_nxt;
  logic             feq_r, feq_nxt, fgt_r, fgt_nxt, halted_r, halted_nxt;
  smc_pkg::fault_t  fault_r, fault_nxt;
  smc_pkg::word_t   top_r, top_nxt, rd_r, rd_nxt, rnd_r, rnd_nxt;
  smc_pkg::word_t   a_r, a_nxt, b_r, b_nxt, opnd_r, opnd_nxt;
  smc_pkg::opcode_t op_r, op_nxt;
  logic             opbad_r, opbad_nxt;
  logic [RA_W-1:0]  rsv_r, rsv_nxt;
  logic [DCW-1:0]   num_r, num_nxt, cnt_r, cnt_nxt;
  logic [DS_AW-1:0] alu_dst_r, alu_dst_nxt;
  smc_pkg::out_t    out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Memory ports.
  logic             mm_we, ds_we, rs_we;
  logic [MEM_AW-1:0] mm_waddr, mm_raddr;
  logic [DS_AW-1:0] ds_waddr, ds_raddr;
  logic [CS_AW-1:0] rs_waddr, rs_raddr;
  smc_pkg::word_t   mm_wdata, mm_rdata, ds_wdata, ds_rdata;
  logic [RA_W-1:0]  rs_wdata, rs_rdata;

  smc_pkg::alu_req_t alu_req;
  smc_pkg::word_t    alu_a, alu_res;
  logic              alu_done;

  // Condition signals for the execute step.
  logic [MEM_AW:0]  pc1, pc2;
  logic             n1, n2, in_addr_ok, opnd_ok, a_ok, b_ok, idx_ok, take;
  logic             jt_bad, jt_end, dup_bad, dup_under, dup_over;
  logic [W:0]       idx, dup_sum;

  smc_ram #(.DEPTH(smc_pkg::MEM_WORDS), .WIDTH(W)) u_main_mem (
    .clk(clk), .we(mm_we), .waddr(mm_waddr), .wdata(mm_wdata),
    .raddr(mm_raddr), .rdata_r(mm_rdata)
  );

  smc_ram #(.DEPTH(smc_pkg::DATA_STACK_WORDS), .WIDTH(W)) u_data_stack (
    .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
    .raddr(ds_raddr), .rdata_r(ds_rdata)
  );

  smc_ram #(.DEPTH(smc_pkg::CALL_STACK_WORDS), .WIDTH(RA_W)) u_call_stack (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
    .raddr(rs_raddr), .rdata_r(rs_rdata)
  );

  smc_alu u_alu (
    .clk(clk), .rst_n(rst_n), .req(alu_req), .op_a(alu_a), .op_b(b_r),
    .done(alu_done), .result(alu_res)
  );

  // Address and bound checks.
  assign pc1        = {1'b0, pc_r} + 1'b1;
  assign pc2        = {1'b0, pc_r} + 2'd2;
  assign n1         = W'(pc1) < MEM_W;
  assign n2         = W'(pc2) < MEM_W;
  assign in_addr_ok = W'(in_data.address) < MEM_W;
  assign opnd_ok    = !opnd_r[W-1] && (opnd_r < MEM_W);
  assign a_ok       = !a_r[W-1] && (a_r < MEM_W);
  assign b_ok       = !b_r[W-1] && (b_r < MEM_W);
  assign jt_bad     = opnd_r[W-1] || (opnd_r > MEM_W);
  assign jt_end     = opnd_r == MEM_W;
  assign idx        = {(op_r == smc_pkg::OP_AFROMMEM) ? b_r[W-1] : a_r[W-1],
                       (op_r == smc_pkg::OP_AFROMMEM) ? b_r : a_r}
                      + {opnd_r[W-1], opnd_r};
  assign idx_ok     = !idx[W] && (idx[W-1:0] < MEM_W);
  assign dup_bad    = opnd_r[W-1] || (opnd_r == '0);
  assign dup_under  = W'(d_r) < opnd_r;
  assign dup_sum    = (W + 1)'(d_r) + {1'b0, opnd_r};
  assign dup_over   = dup_sum > DSW_X;
  assign alu_a      = a_r;

  // Branch condition from the compare flags.
  always_comb begin
    case (op_r)
      smc_pkg::OP_JE:  take = feq_r;
      smc_pkg::OP_JNE: take = !feq_r;
      smc_pkg::OP_JL:  take = !feq_r && !fgt_r;
      smc_pkg::OP_JG:  take = fgt_r;
      smc_pkg::OP_JLE: take = !fgt_r;
      smc_pkg::OP_JGE: take = feq_r || fgt_r;
      default:         take = 1'b1;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smc_pkg::ST_IDLE;
      pc_r        <= '0;
      d_r         <= '0;
      r_r         <= '0;
      feq_r       <= 1'b0;
      fgt_r       <= 1'b0;
      halted_r    <= 1'b0;
      fault_r     <= smc_pkg::FLT_NONE;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      d_r         <= d_nxt;
      r_r         <= r_nxt;
      feq_r       <= feq_nxt;
      fgt_r       <= fgt_nxt;
      halted_r    <= halted_nxt;
      fault_r     <= fault_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    pend_pc_r <= pend_pc_nxt;
    pend_d_r  <= pend_d_nxt;
    pend_r_r  <= pend_r_nxt;
    rd_r      <= rd_nxt;
    rnd_r     <= rnd_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    opnd_r    <= opnd_nxt;
    op_r      <= op_nxt;
    opbad_r   <= opbad_nxt;
    rsv_r     <= rsv_nxt;
    num_r     <= num_nxt;
    cnt_r     <= cnt_nxt;
    alu_dst_r <= alu_dst_nxt;
    out_r     <= out_nxt;
  end

  // Sequencer: next state, memory ports and ALU requests.
  always_comb begin
    smc_pkg::fault_t err;
    err           = smc_pkg::FLT_NONE;
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    d_nxt         = d_r;
    r_nxt         = r_r;
    feq_nxt       = feq_r;
    fgt_nxt       = fgt_r;
    halted_nxt    = halted_r;
    fault_nxt     = fault_r;
    top_nxt       = top_r;
    out_valid_nxt = out_valid_r;
    pend_pc_nxt   = pend_pc_r;
    pend_d_nxt    = pend_d_r;
    pend_r_nxt    = pend_r_r;
    rd_nxt        = rd_r;
    rnd_nxt       = rnd_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    opnd_nxt      = opnd_r;
    op_nxt        = op_r;
    opbad_nxt     = opbad_r;
    rsv_nxt       = rsv_r;
    num_nxt       = num_r;
    cnt_nxt       = cnt_r;
    alu_dst_nxt   = alu_dst_r;
    out_nxt       = out_r;
    mm_we         = 1'b0;
    mm_waddr      = MEM_AW'(in_data.address);
    mm_wdata      = W'(in_data.write_data);
    mm_raddr      = pc_r;
    ds_we         = 1'b0;
    ds_waddr      = DS_AW'(d_r);
    ds_wdata      = opnd_r;
    ds_raddr      = DS_AW'(d_r - 1'b1);
    rs_we         = 1'b0;
    rs_waddr      = r_r[CS_AW-1:0];
    rs_wdata      = RA_W'(pc2);
    rs_raddr      = CS_AW'(r_r - 1'b1);
    alu_req.start = 1'b0;
    alu_req.func  = smc_pkg::ALU_ADD;

    case (state_r)
      // Take a request and start the matching access.
      smc_pkg::ST_IDLE: begin
        if (in_valid) begin
          rd_nxt  = '0;
          rnd_nxt = W'(in_data.random_value);
          case (in_data.operation)
            smc_pkg::OPER_LOAD: begin
              mm_we     = in_addr_ok;
              state_nxt = smc_pkg::ST_RESP;
            end
            smc_pkg::OPER_READ: begin
              mm_raddr  = MEM_AW'(in_data.address);
              state_nxt = smc_pkg::ST_MEMRD;
            end
            smc_pkg::OPER_EXEC: begin
              state_nxt = halted_r ? smc_pkg::ST_RESP : smc_pkg::ST_FETCH;
            end
            default: state_nxt = smc_pkg::ST_RESP;
          endcase
        end
      end

      smc_pkg::ST_MEMRD: begin
        rd_nxt    = in_addr_ok ? mm_rdata : '0;
        state_nxt = smc_pkg::ST_RESP;
      end

      // Opcode, top of stack and return address arrive; fetch the operand.
      smc_pkg::ST_FETCH: begin
        opbad_nxt = mm_rdata > W'(smc_pkg::OP_BREAK);
        op_nxt    = smc_pkg::opcode_t'(mm_rdata[4:0]);
        b_nxt     = ds_rdata;
        rsv_nxt   = rs_rdata;
        mm_raddr  = pc1[MEM_AW-1:0];
        ds_raddr  = DS_AW'(d_r - 2'd2);
        state_nxt = smc_pkg::ST_OPND;
      end

      smc_pkg::ST_OPND: begin
        opnd_nxt  = mm_rdata;
        a_nxt     = ds_rdata;
        state_nxt = smc_pkg::ST_EXEC;
      end

      // Check the instruction, then act on it or latch the fault.
      smc_pkg::ST_EXEC: begin
        pend_pc_nxt = pc_r;
        pend_d_nxt  = d_r;
        pend_r_nxt  = r_r;
        state_nxt   = smc_pkg::ST_COMMIT;
        if (opbad_r) begin
          err = smc_pkg::FLT_BAD_OP;
        end else begin
          case (op_r)
            smc_pkg::OP_PUSH: begin
              if (!n1) err = smc_pkg::FLT_CODE_END;
              else if (d_r >= DS_FULL) err = smc_pkg::FLT_OVERFLOW;
              else if (!n2) err = smc_pkg::FLT_CODE_END;
              else begin
                ds_we       = 1'b1;
                pend_pc_nxt = pc2[MEM_AW-1:0];
                pend_d_nxt  = d_r + 1'b1;
              end
            end
            smc_pkg::OP_POP: begin
              if (d_r == '0) err = smc_pkg::FLT_UNDERFLOW;
              else if (!n1) err = smc_pkg::FLT_CODE_END;
              else begin
                pend_pc_nxt = pc1[MEM_AW-1:0];
                pend_d_nxt  = d_r - 1'b1;
              end
            end
            smc_pkg::OP_ADD, smc_pkg::OP_SUB, smc_pkg::OP_MULT, smc_pkg::OP_DIV: begin
              if (d_r < DCW'(2)) err = smc_pkg::FLT_UNDERFLOW;
              else if (op_r == smc_pkg::OP_DIV && b_r == '0) err = smc_pkg::FLT_DIV_ZERO;
              else if (!n1) err = smc_pkg::FLT_CODE_END;
              else begin
                alu_req.start = 1'b1;
                case (op_r)
                  smc_pkg::OP_ADD:  alu_req.func = smc_pkg::ALU_ADD;
                  smc_pkg::OP_SUB:  alu_req.func = smc_pkg::ALU_SUB;
                  smc_pkg::OP_MULT: alu_req.func = smc_pkg::ALU_MUL;
                  default:          alu_req.func = smc_pkg::ALU_DIV;
                endcase
                alu_dst_nxt = DS_AW'(d_r - 2'd2);
                pend_pc_nxt = pc1[MEM_AW-1:0];
                pend_d_nxt  = d_r - 1'b1;
                state_nxt   = smc_pkg::ST_ALU;
              end
            end
            smc_pkg::OP_JMP, smc_pkg::OP_JE, smc_pkg::OP_JNE, smc_pkg::OP_JL,
            smc_pkg::OP_JG, smc_pkg::OP_JLE, smc_pkg::OP_JGE: begin
              if (!n1) err = smc_pkg::FLT_CODE_END;
              else if (take && jt_bad) err = smc_pkg::FLT_BAD_ADDR;
              else if (take && jt_end) err = smc_pkg::FLT_CODE_END;
              else if (!take && !n2) err = smc_pkg::FLT_CODE_END;
              else pend_pc_nxt = take ? MEM_AW'(opnd_r) : pc2[MEM_AW-1:0];
            end
            smc_pkg::OP_CMP: begin
              if (d_r < DCW'(2)) err = smc_pkg::FLT_UNDERFLOW;
              else if (!n1) err = smc_pkg::FLT_CODE_END;
              else begin
                feq_nxt     = a_r == b_r;
                fgt_nxt     = (a_r != b_r) && ($signed(a_r) > $signed(b_r));
                pend_pc_nxt = pc1[MEM_AW-1:0];
              end
            end
            smc_pkg::OP_FROMMEM, smc_pkg::OP_TOMEM: begin
              if (!n1) err = smc_pkg::FLT_CODE_END;
              else if (!opnd_ok) err = smc_pkg::FLT_BAD_ADDR;
              else if (op_r == smc_pkg::OP_FROMMEM && d_r >= DS_FULL)
                err = smc_pkg::FLT_OVERFLOW;
              else if (op_r == smc_pkg::OP_TOMEM && d_r == '0)
                err = smc_pkg::FLT_UNDERFLOW;
              else if (!n2) err = smc_pkg::FLT_CODE_END;
              else begin
                pend_pc_nxt = pc2[MEM_AW-1:0];
                if (op_r == smc_pkg::OP_FROMMEM) begin
                  mm_raddr   = MEM_AW'(opnd_r);
                  pend_d_nxt = d_r + 1'b1;
                  state_nxt  = smc_pkg::ST_MPUSH;
                end else begin
                  mm_we    = 1'b1;
                  mm_waddr = MEM_AW'(opnd_r);
                  mm_wdata = b_r;
                end
              end
            end
            smc_pkg::OP_RFROMMEM: begin
              if (d_r == '0) err = smc_pkg::FLT_UNDERFLOW;
              else if (!b_ok) err = smc_pkg::FLT_BAD_ADDR;
              else if (d_r >= DS_FULL) err = smc_pkg::FLT_OVERFLOW;
              else if (!n1) err = smc_pkg::FLT_CODE_END;
              else begin
                mm_raddr    = MEM_AW'(b_r);
                pend_pc_nxt = pc1[MEM_AW-1:0];
                pend_d_nxt  = d_r + 1'b1;
                state_nxt   = smc_pkg::ST_MPUSH;
              end
            end
            smc_pkg::OP_RTOMEM: begin
              if (d_r < DCW'(2)) err = smc_pkg::FLT_UNDERFLOW;
              else if (!a_ok) err = smc_pkg::FLT_BAD_ADDR;
              else if (!n1) err = smc_pkg::FLT_CODE_END;
              else begin
                mm_we       = 1'b1;
                mm_waddr    = MEM_AW'(a_r);
                mm_wdata    = b_r;
                pend_pc_nxt = pc1[MEM_AW-1:0];
              end
            end
            smc_pkg::OP_CALL: begin
              if (r_r >= CS_FULL) err = smc_pkg::FLT_CALL_OVF;
              else if (!n1) err = smc_pkg::FLT_CODE_END;
              else if (!opnd_ok) err = smc_pkg::FLT_BAD_ADDR;
              else begin
                rs_we       = 1'b1;
                pend_pc_nxt = MEM_AW'(opnd_r);
                pend_r_nxt  = r_r + 1'b1;
              end
            end
            smc_pkg::OP_RET: begin
              if (r_r == '0) err = smc_pkg::FLT_CALL_EMPTY;
              else if (rsv_r >= MEM_RA) err = smc_pkg::FLT_BAD_ADDR;
              else begin
                pend_pc_nxt = MEM_AW'(rsv_r);
                pend_r_nxt  = r_r - 1'b1;
              end
            end
            smc_pkg::OP_DUP: begin
              if (!n1) err = smc_pkg::FLT_CODE_END;
              else if (dup_bad) err = smc_pkg::FLT_BAD_DUP;
              else if (dup_under) err = smc_pkg::FLT_UNDERFLOW;
              else if (dup_over) err = smc_pkg::FLT_OVERFLOW;
              else if (!n2) err = smc_pkg::FLT_CODE_END;
              else begin
                num_nxt     = DCW'(opnd_r);
                cnt_nxt     = '0;
                pend_pc_nxt = pc2[MEM_AW-1:0];
                pend_d_nxt  = DCW'(dup_sum);
                state_nxt   = smc_pkg::ST_DUPRD;
              end
            end
            smc_pkg::OP_RANDINT: begin
              if (d_r >= DS_FULL) err = smc_pkg::FLT_OVERFLOW;
              else if (!n1) err = smc_pkg::FLT_CODE_END;
              else begin
                ds_we       = 1'b1;
                ds_wdata    = rnd_r;
                pend_pc_nxt = pc1[MEM_AW-1:0];
                pend_d_nxt  = d_r + 1'b1;
              end
            end
            smc_pkg::OP_SWAP: begin
              if (d_r < DCW'(2)) err = smc_pkg::FLT_UNDERFLOW;
              else if (!n1) err = smc_pkg::FLT_CODE_END;
              else begin
                ds_we       = 1'b1;
                ds_waddr    = DS_AW'(d_r - 1'b1);
                ds_wdata    = a_r;
                pend_pc_nxt = pc1[MEM_AW-1:0];
                state_nxt   = smc_pkg::ST_SWAP2;
              end
            end
            smc_pkg::OP_INC, smc_pkg::OP_DEC: begin
              if (d_r == '0) err = smc_pkg::FLT_UNDERFLOW;
              else if (!n1) err = smc_pkg::FLT_CODE_END;
              else begin
                alu_req.start = 1'b1;
                alu_req.func  = (op_r == smc_pkg::OP_INC) ? smc_pkg::ALU_INC
                                                          : smc_pkg::ALU_DEC;
                alu_dst_nxt   = DS_AW'(d_r - 1'b1);
                pend_pc_nxt   = pc1[MEM_AW-1:0];
                state_nxt     = smc_pkg::ST_ALU;
              end
            end
            smc_pkg::OP_AFROMMEM, smc_pkg::OP_ATOMEM: begin
              if (op_r == smc_pkg::OP_AFROMMEM && d_r == '0)
                err = smc_pkg::FLT_UNDERFLOW;
              else if (op_r == smc_pkg::OP_ATOMEM && d_r < DCW'(2))
                err = smc_pkg::FLT_UNDERFLOW;
              else if (!n1) err = smc_pkg::FLT_CODE_END;
              else if (!idx_ok) err = smc_pkg::FLT_BAD_ADDR;
              else if (op_r == smc_pkg::OP_AFROMMEM && d_r >= DS_FULL)
                err = smc_pkg::FLT_OVERFLOW;
              else if (!n2) err = smc_pkg::FLT_CODE_END;
              else begin
                pend_pc_nxt = pc2[MEM_AW-1:0];
                if (op_r == smc_pkg::OP_AFROMMEM) begin
                  mm_raddr   = MEM_AW'(idx);
                  pend_d_nxt = d_r + 1'b1;
                  state_nxt  = smc_pkg::ST_MPUSH;
                end else begin
                  mm_we    = 1'b1;
                  mm_waddr = MEM_AW'(idx);
                  mm_wdata = b_r;
                end
              end
            end
            smc_pkg::OP_QUIT: begin
              halted_nxt = 1'b1;
              fault_nxt  = smc_pkg::FLT_NONE;
            end
            default: begin
              // Print, nop and breakpoint only advance.
              if (!n1) err = smc_pkg::FLT_CODE_END;
              else pend_pc_nxt = pc1[MEM_AW-1:0];
            end
          endcase
        end
        if (err != smc_pkg::FLT_NONE) begin
          halted_nxt  = 1'b1;
          fault_nxt   = err;
          pend_pc_nxt = pc_r;
          pend_d_nxt  = d_r;
          pend_r_nxt  = r_r;
          feq_nxt     = feq_r;
          fgt_nxt     = fgt_r;
          state_nxt   = smc_pkg::ST_COMMIT;
        end
      end

      // Write the ALU result back into the stack.
      smc_pkg::ST_ALU: begin
        if (alu_done) begin
          ds_we     = 1'b1;
          ds_waddr  = alu_dst_r;
          ds_wdata  = alu_res;
          state_nxt = smc_pkg::ST_COMMIT;
        end
      end

      // Push the word read from main memory.
      smc_pkg::ST_MPUSH: begin
        ds_we     = 1'b1;
        ds_wdata  = mm_rdata;
        state_nxt = smc_pkg::ST_COMMIT;
      end

      smc_pkg::ST_SWAP2: begin
        ds_we     = 1'b1;
        ds_waddr  = DS_AW'(d_r - 2'd2);
        ds_wdata  = b_r;
        state_nxt = smc_pkg::ST_COMMIT;
      end

      // Multi-word dup: read one source word, then write its copy.
      smc_pkg::ST_DUPRD: begin
        ds_raddr  = DS_AW'(d_r - num_r + cnt_r);
        state_nxt = smc_pkg::ST_DUPWR;
      end

      smc_pkg::ST_DUPWR: begin
        ds_we     = 1'b1;
        ds_waddr  = DS_AW'(d_r + cnt_r);
        ds_wdata  = ds_rdata;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = (cnt_nxt == num_r) ? smc_pkg::ST_COMMIT : smc_pkg::ST_DUPRD;
      end

      // Commit the new pc and depths and read back the top of stack.
      smc_pkg::ST_COMMIT: begin
        pc_nxt    = pend_pc_r;
        d_nxt     = pend_d_r;
        r_nxt     = pend_r_r;
        ds_raddr  = DS_AW'(pend_d_r - 1'b1);
        state_nxt = smc_pkg::ST_TOP;
      end

      smc_pkg::ST_TOP: begin
        top_nxt   = (d_r != '0) ? ds_rdata : '0;
        state_nxt = smc_pkg::ST_RESP;
      end

      // Build the result.
      smc_pkg::ST_RESP: begin
        out_nxt.read_data       = smc_pkg::DATA_W'(rd_r);
        out_nxt.program_counter = smc_pkg::ADDR_W'(pc_r);
        out_nxt.stack_depth     = smc_pkg::DEPTH_W'(d_r);
        out_nxt.top_value       = smc_pkg::DATA_W'(top_r);
        out_nxt.call_depth      = smc_pkg::DEPTH_W'(r_r);
        out_nxt.flag_equal      = feq_r;
        out_nxt.flag_greater    = fgt_r;
        out_nxt.halted          = halted_r;
        out_nxt.fault_code      = fault_r;
        out_valid_nxt           = 1'b1;
        state_nxt               = smc_pkg::ST_WAIT;
      end

      smc_pkg::ST_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = smc_pkg::ST_IDLE;
        end
      end

      default: state_nxt = smc_pkg::ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == smc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A new request is never taken while a result is still pending.
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid_r)
    else $error("request accepted while a result is pending");

  // Stack depths stay within their stores.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (d_r <= DS_FULL) && (r_r <= CS_FULL))
    else $error("stack depth beyond its store");

  // Once halted, the core stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt cleared without reset");

  // A latched fault always comes with the halt bit.
  a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (fault_r != smc_pkg::FLT_NONE) |-> halted_r)
    else $error("fault latched without halt");

  // A halted core changes neither pc nor depths.
  a_halt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> $stable(pc_r) && $stable(d_r) && $stable(r_r))
    else $error("state changed while halted");

endmodule

// ----- rtl/smc_ram.sv -----
// ----------------------------------------------------------------------------
// smc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module smc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

// ----- rtl/smc_alu.sv -----
// ----------------------------------------------------------------------------
// smc_alu: shared arithmetic unit
// Add, subtract, multiply, increment and decrement with a registered result;
// signed division by a restoring loop of one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smc_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  smc_pkg::alu_req_t req,
  input  smc_pkg::word_t    op_a,
  input  smc_pkg::word_t    op_b,
  output logic              done,
  output smc_pkg::word_t    result
);

  localparam int W   = smc_pkg::WORD_BITS;
  localparam int CNW = $clog2(W + 1);

  logic           busy_r, done_r, neg_r;
  logic [CNW-1:0] cnt_r;
  logic [W:0]     rem_r;
  logic [W-1:0]   quo_r, den_r, res_r;
  logic [W-1:0]   mag_a, mag_b, mul_lo;
  logic [W:0]     shifted, trial;

  // Operand magnitudes for the divider and the low half of the product.
  assign mag_a   = op_a[W-1] ? (~op_a + 1'b1) : op_a;
  assign mag_b   = op_b[W-1] ? (~op_b + 1'b1) : op_b;
  assign mul_lo  = op_a * op_b;
  assign shifted = {rem_r[W-1:0], quo_r[W-1]};
  assign trial   = shifted - {1'b0, den_r};

  // Control: busy while dividing, a one-cycle done pulse when each operation ends.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (req.func == smc_pkg::ALU_DIV) begin
          busy_r <= 1'b1;
        end else begin
          done_r <= 1'b1;
        end
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      case (req.func)
        smc_pkg::ALU_ADD: res_r <= op_a + op_b;
        smc_pkg::ALU_SUB: res_r <= op_a - op_b;
        smc_pkg::ALU_MUL: res_r <= mul_lo;
        smc_pkg::ALU_INC: res_r <= op_b + 1'b1;
        smc_pkg::ALU_DEC: res_r <= op_b - 1'b1;
        smc_pkg::ALU_DIV: begin
          rem_r <= '0;
          quo_r <= mag_a;
          den_r <= mag_b;
          neg_r <= op_a[W-1] ^ op_b[W-1];
          cnt_r <= CNW'(W);
        end
        default: res_r <= '0;
      endcase
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        // One restoring step.
        if (!trial[W]) begin
          rem_r <= trial;
          quo_r <= {quo_r[W-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          quo_r <= {quo_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
      end else begin
        res_r <= neg_r ? (~quo_r + 1'b1) : quo_r;
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
